FILE: rtl/core/iafp_pkg.sv
// shared types and constants for the imu angle frame parser
`timescale 1ns / 1ps

package iafp_pkg;

   // frame layout
   localparam logic [7:0] HDR_BYTE        = 8'h55;
   localparam logic [7:0] ANGLE_TYPE      = 8'h53;
   localparam logic [3:0] POS_HEADER      = 4'd0;
   localparam logic [3:0] POS_TYPE        = 4'd1;
   localparam logic [3:0] POS_FIRST_ANGLE = 4'd2;
   localparam logic [3:0] POS_LAST_ANGLE  = 4'd7;
   localparam logic [3:0] POS_CHECKSUM    = 4'd10;

   localparam int ANGLE_BYTES = 6;
   localparam int RAW_W       = 16;
   localparam int DEG_W       = 24;

   // what the assembler reports for the beat being taken
   typedef struct packed {
      logic                    good;
      logic signed [RAW_W-1:0] roll_raw;
      logic signed [RAW_W-1:0] pitch_raw;
      logic signed [RAW_W-1:0] yaw_raw;
   } frame_type;

   // one result beat
   typedef struct packed {
      logic signed [DEG_W-1:0] roll;
      logic signed [DEG_W-1:0] pitch;
      logic signed [DEG_W-1:0] yaw;
   } angles_type;

endpackage

FILE: rtl/core/imu_angle_frame_parser.sv
// top level of the imu angle frame parser
`timescale 1ns / 1ps

// Takes one serial byte per req beat and assembles 11-byte frames: header 0x55,
// type, six little-endian angle bytes (roll, pitch, yaw), two summed bytes and
// an 8-bit checksum of the first ten bytes. A frame of type 0x53 with a good
// checksum gives one rsp beat holding roll, pitch and yaw as signed q15 degrees
// (raw times 180); any other frame, and any non-header byte between frames, is
// dropped with no beat. A byte can be taken every cycle while req_ready is high:
// the counter, sum and angle store update in the cycle the byte is taken, and
// the result of the checksum byte is loaded into the output register, or into
// the one skid entry that backs it when rsp is stalled, so req_ready only drops
// when two results are waiting on a stalled rsp side.

module imu_angle_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [23:0] rsp_roll_deg_q15,
   output logic signed [23:0] rsp_pitch_deg_q15,
   output logic signed [23:0] rsp_yaw_deg_q15
);

   iafp_pkg::frame_type  frame;
   iafp_pkg::angles_type res;
   logic                 take;
   logic                 res_fire;
   logic                 out_free;

   // output register and skid entry
   logic                 out_valid_ff, out_valid_in;
   iafp_pkg::angles_type out_ff, out_in;
   logic                 skid_valid_ff, skid_valid_in;
   iafp_pkg::angles_type skid_ff, skid_in;

   assign req_ready = !skid_valid_ff;
   assign take      = req_valid && req_ready;

   iafp_frame_asm u_asm (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (take),
      .rx_byte    (req_rx_byte),
      .frame      (frame)
   );

   iafp_deg_scale u_roll  (.raw(frame.roll_raw),  .deg(res.roll));
   iafp_deg_scale u_pitch (.raw(frame.pitch_raw), .deg(res.pitch));
   iafp_deg_scale u_yaw   (.raw(frame.yaw_raw),   .deg(res.yaw));

   // a finished frame on this beat
   assign res_fire = take && frame.good;
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // skid drains first, no new result can fire while it is full
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_fire;
            out_in       = res;
         end
      end else if (res_fire) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_roll_deg_q15  = out_ff.roll;
   assign rsp_pitch_deg_q15 = out_ff.pitch;
   assign rsp_yaw_deg_q15   = out_ff.yaw;

endmodule

FILE: rtl/core/iafp_frame_asm.sv
// frame assembler: position counter, running sum, type byte and angle byte store
`timescale 1ns / 1ps

module iafp_frame_asm (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          rx_byte,
   output iafp_pkg::frame_type frame
);

   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] angle_ff [iafp_pkg::ANGLE_BYTES];
   logic       wr_en;
   logic [2:0] wr_idx;
   logic       good;

   assign wr_idx = 3'(pos_ff - iafp_pkg::POS_FIRST_ANGLE);

   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      type_in = type_ff;
      wr_en   = 1'b0;
      good    = 1'b0;
      if (byte_valid) begin
         priority if (pos_ff == iafp_pkg::POS_HEADER) begin
            // hunt for header, anything else is dropped
            if (rx_byte == iafp_pkg::HDR_BYTE) begin
               sum_in = rx_byte;
               pos_in = iafp_pkg::POS_TYPE;
            end
         end else if (pos_ff == iafp_pkg::POS_CHECKSUM) begin
            pos_in = iafp_pkg::POS_HEADER;
            good   = (type_ff == iafp_pkg::ANGLE_TYPE) && (sum_ff == rx_byte);
         end else begin
            if (pos_ff == iafp_pkg::POS_TYPE) begin
               type_in = rx_byte;
            end else if (pos_ff <= iafp_pkg::POS_LAST_ANGLE) begin
               wr_en = 1'b1;
            end
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= iafp_pkg::POS_HEADER;
         sum_ff  <= '0;
         type_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         type_ff <= type_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         angle_ff[wr_idx] <= rx_byte;
      end
   end

   always_comb begin
      frame.good      = good;
      frame.roll_raw  = {angle_ff[1], angle_ff[0]};
      frame.pitch_raw = {angle_ff[3], angle_ff[2]};
      frame.yaw_raw   = {angle_ff[5], angle_ff[4]};
   end

endmodule

FILE: rtl/core/iafp_deg_scale.sv
// raw angle times 180 as shift-add, giving q15 degrees
`timescale 1ns / 1ps

module iafp_deg_scale (
   input  logic signed [iafp_pkg::RAW_W-1:0] raw,
   output logic signed [iafp_pkg::DEG_W-1:0] deg
);

   logic signed [iafp_pkg::DEG_W-1:0] ext;

   assign ext = iafp_pkg::DEG_W'(raw);

   // 180 = 128 + 32 + 16 + 4
   assign deg = (ext <<< 7) + (ext <<< 5) + (ext <<< 4) + (ext <<< 2);

endmodule

FILE: rtl/core/iafp_checker.sv
// port-level checks for the imu angle frame parser, bound to the top level
`timescale 1ns / 1ps

module iafp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_roll_deg_q15,
   input logic [23:0] rsp_pitch_deg_q15,
   input logic [23:0] rsp_yaw_deg_q15
);

   // reset leaves no beat pending and the byte side open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("rsp pending or req blocked after reset");

   // a new result only follows a taken byte
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("rsp beat with no byte taken before it");

   // byte side blocks only when a stalled result is waiting
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
      else $error("req_ready dropped with rsp side free");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_roll_deg_q15)
         && $stable(rsp_pitch_deg_q15) && $stable(rsp_yaw_deg_q15)))
      else $error("stalled rsp beat changed");

endmodule

bind imu_angle_frame_parser iafp_checker u_iafp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_roll_deg_q15  (rsp_roll_deg_q15),
   .rsp_pitch_deg_q15 (rsp_pitch_deg_q15),
   .rsp_yaw_deg_q15   (rsp_yaw_deg_q15)
);

FILE: test/tb_imu_angle_frame_parser.sv
// testbench for the imu angle frame parser
`timescale 1ns / 1ps

// Drives the serial byte stream one req beat at a time and checks every rsp
// beat against a predictor that assembles frames the same way the parser
// should. A short directed script comes first. It covers noise bytes before
// any frame, a frame with the most negative, most positive and zero angles, and
// a frame of the wrong type. Random traffic follows: mostly well-formed
// frames with random angles, plus frames of the wrong type, frames with a bad
// checksum and stray bytes that knock the framing out of step. The sender
// idles in bursts. The receiver stalls on a pattern of its own. It also holds
// off once for a long stretch, so that the output buffer fills and req_ready
// drops.

module tb_imu_angle_frame_parser;

   localparam logic [7:0] OTHER_TYPE   = 8'h54;  // any type but the angle type
   localparam int         FRAME_BYTES  = 11;
   localparam int         RANDOM_BYTES = 1400;   // frame bytes in the random part
   localparam int         LONG_HOLD    = 300;    // cycles of the one long rsp stall
   localparam int         DRAIN_CYCLES = 20;

   typedef enum int {FRAME_GOOD, FRAME_WRONG_TYPE, FRAME_BAD_SUM} frame_kind_type;

   // directed script row: a byte, plus the angles it must produce where they
   // are plain from the frame contents
   typedef struct {
      logic [7:0]         rx;
      bit                 typed;
      logic signed [23:0] roll;
      logic signed [23:0] pitch;
      logic signed [23:0] yaw;
   } script_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_roll_deg_q15;
   logic signed [23:0] rsp_pitch_deg_q15;
   logic signed [23:0] rsp_yaw_deg_q15;

   imu_angle_frame_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_roll_deg_q15  (rsp_roll_deg_q15),
      .rsp_pitch_deg_q15 (rsp_pitch_deg_q15),
      .rsp_yaw_deg_q15   (rsp_yaw_deg_q15)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // frame assembly as the parser should do it
   // ---------------------------------------------------------------------
   logic [3:0] frame_pos  = iafp_pkg::POS_HEADER;
   logic [7:0] frame_sum  = 8'h00;
   logic [7:0] frame_kind = 8'h00;
   logic [7:0] angle_store [iafp_pkg::ANGLE_BYTES];

   iafp_pkg::angles_type angles_due [$];   // angles still owed by the parser
   int                   angles_seen = 0;
   int                   failures    = 0;

   // little-endian raw angle times 180, kept to 24 bits
   function automatic logic signed [23:0] to_degrees(logic [7:0] lo, logic [7:0] hi);
      logic signed [15:0] raw;
      logic signed [31:0] prod;
      raw  = {hi, lo};
      prod = raw * 32'sd180;
      return prod[23:0];
   endfunction

   task automatic assemble_byte(input logic [7:0] b, output bit done,
                                output iafp_pkg::angles_type res);
      done = 1'b0;
      res  = '0;
      if (frame_pos == iafp_pkg::POS_HEADER) begin
         // only a header starts a frame; anything else is dropped
         if (b == iafp_pkg::HDR_BYTE) begin
            frame_sum = b;
            frame_pos = iafp_pkg::POS_TYPE;
         end
      end else if (frame_pos != iafp_pkg::POS_CHECKSUM) begin
         // a header value here is plain data
         if (frame_pos == iafp_pkg::POS_TYPE)
            frame_kind = b;
         else if (frame_pos <= iafp_pkg::POS_LAST_ANGLE)
            angle_store[3'(frame_pos - iafp_pkg::POS_FIRST_ANGLE)] = b;
         frame_sum = frame_sum + b;
         frame_pos = frame_pos + 4'd1;
      end else begin
         // checksum byte: back to hunting for a header either way
         frame_pos = iafp_pkg::POS_HEADER;
         if (frame_kind == iafp_pkg::ANGLE_TYPE && frame_sum == b) begin
            done      = 1'b1;
            res.roll  = to_degrees(angle_store[0], angle_store[1]);
            res.pitch = to_degrees(angle_store[2], angle_store[3]);
            res.yaw   = to_degrees(angle_store[4], angle_store[5]);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // req side: bursts of beats with random gaps between them
   // ---------------------------------------------------------------------
   int burst_left = 0;

   // entered at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input bit typed,
                            input iafp_pkg::angles_type want);
      bit                   done;
      iafp_pkg::angles_type res;
      int                   gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      // beat taken at this edge
      assemble_byte(b, done, res);
      if (typed)
         angles_due.push_back(want);
      else if (done)
         angles_due.push_back(res);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_frame(input frame_kind_type kind);
      logic [7:0] frame [FRAME_BYTES];
      logic [7:0] sum;
      frame[0] = iafp_pkg::HDR_BYTE;
      frame[1] = iafp_pkg::ANGLE_TYPE;
      if (kind == FRAME_WRONG_TYPE)
         while (frame[1] == iafp_pkg::ANGLE_TYPE)
            frame[1] = 8'($urandom);
      sum = frame[0] + frame[1];
      for (int i = 2; i < FRAME_BYTES - 1; i++) begin
         frame[i] = 8'($urandom);
         sum      = sum + frame[i];
      end
      frame[FRAME_BYTES-1] = sum;
      if (kind == FRAME_BAD_SUM)
         frame[FRAME_BYTES-1] = sum ^ 8'($urandom_range(1, 255));
      for (int i = 0; i < FRAME_BYTES; i++)
         send_byte(frame[i], 1'b0, '0);
   endtask

   // ---------------------------------------------------------------------
   // main stimulus
   // ---------------------------------------------------------------------
   script_row_type script [24];

   initial begin : stimulus
      int                   frame_bytes;
      int                   pick;
      bit                   paused;
      iafp_pkg::angles_type want;

      // noise, then a good frame with a 0x55 among the summed bytes, then a
      // well-summed frame of the wrong type
      script = '{
         '{8'h00,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'hFF,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{iafp_pkg::HDR_BYTE,   1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{iafp_pkg::ANGLE_TYPE, 1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'h00,                1'b0, 24'sd0, 24'sd0, 24'sd0},   // roll 0x8000
         '{8'h80,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'hFF,                1'b0, 24'sd0, 24'sd0, 24'sd0},   // pitch 0x7fff
         '{8'h7F,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'h00,                1'b0, 24'sd0, 24'sd0, 24'sd0},   // yaw 0
         '{8'h00,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{iafp_pkg::HDR_BYTE,   1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'hAA,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'hA5,                1'b1, -24'sd5898240, 24'sd5898060, 24'sd0},
         '{iafp_pkg::HDR_BYTE,   1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{OTHER_TYPE,           1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'hFF,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'hFF,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'h01,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'h00,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'h34,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'h12,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'h00,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'h00,                1'b0, 24'sd0, 24'sd0, 24'sd0},
         '{8'hEE,                1'b0, 24'sd0, 24'sd0, 24'sd0}    // right sum, wrong type
      };

      // synchronous reset, released at a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         want.roll  = script[i].roll;
         want.pitch = script[i].pitch;
         want.yaw   = script[i].yaw;
         send_byte(script[i].rx, script[i].typed, want);
      end

      // random part: mostly good frames, some broken ones, some stray bytes
      frame_bytes = 0;
      paused      = 1'b0;
      while (frame_bytes < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_frame(FRAME_GOOD);
            frame_bytes += FRAME_BYTES;
         end else if (pick < 78) begin
            send_frame(FRAME_WRONG_TYPE);
            frame_bytes += FRAME_BYTES;
         end else if (pick < 88) begin
            send_frame(FRAME_BAD_SUM);
            frame_bytes += FRAME_BYTES;
         end else begin
            // stray bytes; a stray header throws the framing out of step
            repeat ($urandom_range(1, 3))
               send_byte(8'($urandom), 1'b0, '0);
         end

         // once, halfway, hold req until every owed result has drained
         if (!paused && frame_bytes >= RANDOM_BYTES / 2) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            while (angles_due.size() != 0) @(posedge clock);
            @(negedge clock);
         end
      end

      req_valid <= 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
      // any beat showing up now has no expectation and is flagged
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // rsp side: stall pattern of its own, plus one long hold-off
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int mode;
      int span;
      bit held;
      mode = 0;
      span = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && angles_seen >= 15) begin
            // long stall while the sender keeps offering bytes
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(16, 80);
            end
            span--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 5) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // result check
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      iafp_pkg::angles_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         angles_seen++;
         if (angles_due.size() == 0) begin
            failures++;
            $error("unexpected rsp beat: roll %0d pitch %0d yaw %0d",
                   rsp_roll_deg_q15, rsp_pitch_deg_q15, rsp_yaw_deg_q15);
         end else begin
            want = angles_due.pop_front();
            if (rsp_roll_deg_q15 !== want.roll) begin
               failures++;
               $error("roll_deg_q15: expected %0d, got %0d", want.roll, rsp_roll_deg_q15);
            end
            if (rsp_pitch_deg_q15 !== want.pitch) begin
               failures++;
               $error("pitch_deg_q15: expected %0d, got %0d", want.pitch, rsp_pitch_deg_q15);
            end
            if (rsp_yaw_deg_q15 !== want.yaw) begin
               failures++;
               $error("yaw_deg_q15: expected %0d, got %0d", want.yaw, rsp_yaw_deg_q15);
            end
         end
      end
   end

   // hang guard, far beyond the slowest correct run
   initial begin : watchdog
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
